// ----- rtl/bpre_pkg.sv -----
// Package with shared types, constants and state codes for the button pulse report engine.
package bpre_pkg;

    localparam int unsigned NUM_BUTTONS_DEF        = 256;
    localparam int unsigned BUTTONS_PER_REPORT_DEF = 128;
    localparam int unsigned TIME_BITS_DEF          = 32;
    localparam logic [15:0] DEFAULT_HOLD_RESET     = 16'd50;
    localparam logic [15:0] CONSUMER_SENT_RESET    = 16'hFFFF;
    localparam logic [4:0]  REPORT_LAST_BYTE       = 5'd24;
    localparam logic [4:0]  BUTTON_BYTES           = 5'd16;

    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_PULSE   = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    localparam logic [1:0] REPORT_LOW      = 2'd1;
    localparam logic [1:0] REPORT_HIGH     = 2'd2;
    localparam logic [1:0] REPORT_CONSUMER = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  button;
        logic [15:0] cons_usage;
        logic [15:0] hold_ms;
        logic        host_ready;
    } t_in_word;

    typedef struct packed {
        logic [1:0] report_id;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SEND_LOW,
        ST_SEND_HIGH,
        ST_SEND_CONS
    } t_state;

endpackage

// ----- rtl/bpre_deadline_ram.sv -----
// Deadline memory: one synchronous read port and one write port; the read data is registered.
module bpre_deadline_ram
    import bpre_pkg::*;
#(
    parameter int unsigned DEPTH     = NUM_BUTTONS_DEF,
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [TIME_BITS-1:0]     o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [TIME_BITS-1:0]     i_wr_data
);

    logic [TIME_BITS-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- rtl/button_pulse_report_engine_top.sv -----
// Top level of the button pulse report engine.
//
// After a press, release or pulse word, busy stays high while the block picks and sends the
// reports; when report 1 goes out, its first byte leaves in the cycle that picks the reports.
// A tick word first runs a sweep over the deadline memory, one entry per cycle through its
// single read port, ahead of that. A new word can be taken in any cycle in which busy is low.
// Changed reports go out at one byte per cycle on o_strobe, only when host_ready is set in
// the word: 25 bytes each for reports 1 and 2 and 2 bytes for report 3, with o_word.last on
// the final byte for the word. The receiver cannot stall; busy stays high until the last byte
// has gone. After reset the deadline memory is cleared by a pass over every entry, during
// which busy is high.
module button_pulse_report_engine_top
    import bpre_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS        = NUM_BUTTONS_DEF,
    parameter int unsigned BUTTONS_PER_REPORT = BUTTONS_PER_REPORT_DEF,
    parameter int unsigned TIME_BITS          = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output t_out_word   o_word
);

    localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int unsigned CW = $clog2(NUM_BUTTONS + 1);
    localparam logic [CW-1:0] LAST_ENTRY = CW'(NUM_BUTTONS - 1);

    // Registers.
    t_state               r_state, n_state;
    logic [15:0]          r_default_hold;
    logic [127:0]         r_btn_low, r_btn_high, r_sent_low, r_sent_high;
    logic                 r_low_never, r_high_never;
    logic [15:0]          r_cons_val, r_sent_cons;
    logic [TIME_BITS-1:0] r_cons_dl, r_time;
    t_in_word             r_item;
    logic                 r_clearing;
    logic [CW-1:0]        r_addr;
    logic                 r_rd_valid;
    logic [AW-1:0]        r_rd_idx;
    logic [4:0]           r_byte;
    logic                 r_need_high, r_need_cons;

    // Memory port.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [TIME_BITS-1:0] mem_wdata, mem_rdata;

    bpre_deadline_ram #(
        .DEPTH     (NUM_BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata)
    );

    logic                 accept;
    logic                 in_range;
    logic [AW-1:0]        btn_idx;
    logic [15:0]          hold;
    logic [TIME_BITS-1:0] deadline, time_next;
    logic                 expired;
    logic [127:0]         low_after, high_after;
    logic [15:0]          cons_after;
    logic [TIME_BITS-1:0] cons_dl_after;
    logic                 need_low, need_high, need_cons;

    assign accept    = start && !busy;
    assign in_range  = (i_word.button >= 9'd1) && ({23'd0, i_word.button} <= NUM_BUTTONS);
    assign btn_idx   = AW'(i_word.button - 9'd1);
    assign hold      = (i_word.hold_ms == 16'd0) ? r_default_hold : i_word.hold_ms;
    assign deadline  = r_time + TIME_BITS'(hold);
    assign time_next = r_time + TIME_BITS'(1);
    assign mem_raddr = r_addr[AW-1:0];
    assign expired   = (mem_rdata != '0) && (r_time >= mem_rdata);

    // Set or clear one button bit in the report images.
    function automatic void put_button(input logic [AW-1:0] idx, input logic on,
                                       inout logic [127:0] lo, inout logic [127:0] hi);
        int unsigned pos;
        pos = 32'(idx);
        if (pos < BUTTONS_PER_REPORT) begin
            lo[pos[6:0]] = on;
        end else if (pos - BUTTONS_PER_REPORT < 128) begin
            hi[7'(pos - BUTTONS_PER_REPORT)] = on;
        end
    endfunction

    // Button and consumer state after a press, release or pulse, or a sweep hit.
    always_comb begin
        low_after     = r_btn_low;
        high_after    = r_btn_high;
        cons_after    = r_cons_val;
        cons_dl_after = r_cons_dl;
        mem_we        = 1'b0;
        mem_waddr     = btn_idx;
        mem_wdata     = '0;
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr[AW-1:0];
        end else if (accept && i_word.cmd != CMD_TICK) begin
            if (in_range) begin
                put_button(btn_idx, i_word.cmd != CMD_RELEASE, low_after, high_after);
                mem_we    = 1'b1;
                mem_wdata = (i_word.cmd == CMD_PULSE) ? deadline : '0;
            end else if (i_word.cons_usage != 16'd0) begin
                if (i_word.cmd == CMD_RELEASE) begin
                    if (r_cons_val == i_word.cons_usage) begin
                        cons_after = 16'd0;
                    end
                    cons_dl_after = '0;
                end else begin
                    cons_after    = i_word.cons_usage;
                    cons_dl_after = (i_word.cmd == CMD_PULSE) ? deadline : '0;
                end
            end
        end else if (r_state == ST_SWEEP && r_rd_valid && expired) begin
            put_button(r_rd_idx, 1'b0, low_after, high_after);
            mem_we    = 1'b1;
            mem_waddr = r_rd_idx;
        end
        // The consumer deadline is checked once the sweep reaches its last entry.
        if (r_state == ST_SWEEP && r_rd_valid && r_rd_idx == LAST_ENTRY[AW-1:0] &&
            r_cons_dl != '0 && r_time >= r_cons_dl) begin
            cons_after    = 16'd0;
            cons_dl_after = '0;
        end
    end

    assign need_low  = r_low_never || (r_btn_low != r_sent_low);
    assign need_high = r_high_never || (r_btn_high != r_sent_high);
    assign need_cons = r_cons_val != r_sent_cons;

    // Next state and byte output.
    always_comb begin
        n_state   = r_state;
        busy      = (r_state != ST_IDLE) || r_clearing;
        o_strobe  = 1'b0;
        o_word    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_word.cmd == CMD_TICK) ? ST_SWEEP : ST_SEND_LOW;
                end
            end
            ST_SWEEP: begin
                if (r_rd_valid && r_rd_idx == LAST_ENTRY[AW-1:0]) begin
                    n_state = ST_SEND_LOW;
                end
            end
            ST_SEND_LOW: begin
                // First cycle decides which reports go out.
                if (!r_item.host_ready) begin
                    n_state = ST_IDLE;
                end else if (r_byte == 5'd0 && !need_low) begin
                    n_state = need_high ? ST_SEND_HIGH : (need_cons ? ST_SEND_CONS : ST_IDLE);
                end else begin
                    o_strobe          = 1'b1;
                    o_word.report_id  = REPORT_LOW;
                    o_word.byte_index = r_byte;
                    o_word.byte_value = (r_byte < BUTTON_BYTES) ?
                                        r_btn_low[{r_byte[3:0], 3'd0} +: 8] : 8'd0;
                    o_word.last       = (r_byte == REPORT_LAST_BYTE) &&
                                        !r_need_high && !r_need_cons;
                    if (r_byte == REPORT_LAST_BYTE) begin
                        n_state = r_need_high ? ST_SEND_HIGH :
                                  (r_need_cons ? ST_SEND_CONS : ST_IDLE);
                    end
                end
            end
            ST_SEND_HIGH: begin
                o_strobe          = 1'b1;
                o_word.report_id  = REPORT_HIGH;
                o_word.byte_index = r_byte;
                o_word.byte_value = (r_byte < BUTTON_BYTES) ?
                                    r_btn_high[{r_byte[3:0], 3'd0} +: 8] : 8'd0;
                o_word.last       = (r_byte == REPORT_LAST_BYTE) && !r_need_cons;
                if (r_byte == REPORT_LAST_BYTE) begin
                    n_state = r_need_cons ? ST_SEND_CONS : ST_IDLE;
                end
            end
            ST_SEND_CONS: begin
                o_strobe          = 1'b1;
                o_word.report_id  = REPORT_CONSUMER;
                o_word.byte_index = r_byte;
                o_word.byte_value = r_byte[0] ? r_cons_val[15:8] : r_cons_val[7:0];
                o_word.last       = r_byte[0];
                if (r_byte[0]) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and report state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_hold <= DEFAULT_HOLD_RESET;
            r_btn_low      <= '0;
            r_btn_high     <= '0;
            r_sent_low     <= '1;
            r_sent_high    <= '1;
            r_low_never    <= 1'b1;
            r_high_never   <= 1'b1;
            r_cons_val     <= '0;
            r_cons_dl      <= '0;
            r_sent_cons    <= CONSUMER_SENT_RESET;
            r_time         <= '0;
            r_clearing     <= 1'b1;
            r_addr         <= '0;
            r_rd_valid     <= 1'b0;
            r_byte         <= '0;
            r_need_high    <= 1'b0;
            r_need_cons    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_default_hold <= i_cfg_data;
            end
            r_btn_low  <= low_after;
            r_btn_high <= high_after;
            r_cons_val <= cons_after;
            r_cons_dl  <= cons_dl_after;
            r_rd_valid <= 1'b0;

            // Clearing pass after reset.
            if (r_clearing) begin
                if (r_addr == LAST_ENTRY) begin
                    r_clearing <= 1'b0;
                    r_addr     <= '0;
                end else begin
                    r_addr <= r_addr + CW'(1);
                end
            end

            if (accept) begin
                r_byte <= '0;
                if (i_word.cmd == CMD_TICK) begin
                    r_time <= time_next;
                    r_addr <= CW'(1);
                    r_rd_valid <= 1'b1;
                end
            end

            // Sweep: one read issued and one entry checked per cycle; the address
            // returns to entry 0 so the next tick reads it at its accepting edge.
            if (r_state == ST_SWEEP) begin
                r_rd_valid <= r_addr < CW'(NUM_BUTTONS);
                if (r_rd_valid && r_rd_idx == LAST_ENTRY[AW-1:0]) begin
                    r_addr <= '0;
                end else begin
                    r_addr <= r_addr + CW'(1);
                end
            end

            // Report send bookkeeping.
            if (r_state == ST_SEND_LOW && r_item.host_ready) begin
                if (r_byte == 5'd0) begin
                    r_need_high <= need_high;
                    r_need_cons <= need_cons;
                end
                if (r_byte == 5'd0 && !need_low) begin
                    r_byte <= '0;
                end else if (r_byte == REPORT_LAST_BYTE) begin
                    r_byte      <= '0;
                    r_sent_low  <= r_btn_low;
                    r_low_never <= 1'b0;
                end else begin
                    r_byte <= r_byte + 5'd1;
                end
            end
            if (r_state == ST_SEND_HIGH) begin
                if (r_byte == REPORT_LAST_BYTE) begin
                    r_byte       <= '0;
                    r_sent_high  <= r_btn_high;
                    r_high_never <= 1'b0;
                end else begin
                    r_byte <= r_byte + 5'd1;
                end
            end
            if (r_state == ST_SEND_CONS) begin
                r_byte <= r_byte + 5'd1;
                if (r_byte[0]) begin
                    r_sent_cons <= r_cons_val;
                end
            end
        end
    end

    // Item and sweep read index; payload only.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_word;
        end
        r_rd_idx <= r_addr[AW-1:0];
        if (accept) begin
            r_rd_idx <= '0;
        end
    end

    // Assertions.
    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result byte while idle");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> busy)
        else $error("block ready during clearing pass");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.last) |=> (r_state == ST_IDLE))
        else $error("final byte did not end the run");
    a_sweep_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !o_strobe)
        else $error("byte sent during sweep");

endmodule
